/* rtl/stereo_audio_looper_macros.svh */
// Assertion macros used by the looper controller RTL.
`ifndef STEREO_AUDIO_LOOPER_MACROS_SVH
`define STEREO_AUDIO_LOOPER_MACROS_SVH

`ifndef SYNTH
// Concurrent check sampled on the clock, off while reset is low.
`define SAL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("looper check failed");
// Condition in one cycle implies a consequence in the next.
`define SAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("looper sequence check failed");
`else
`define SAL_ASSERT(lbl, clk, rst_n, prop)
`define SAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/sal_pkg.sv */
`timescale 1ns / 1ps
package sal_pkg;

    localparam int unsigned LOOP_DEPTH_DEF  = 524288;
    localparam int unsigned SAMPLE_BITS_DEF = 24;

    // Config port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYBACK_MODE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_ENABLE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BARS_TO_REC   = 3'd6;

    // Register reset values
    localparam logic [15:0] INPUT_GAIN_RST  = 16'd4096;
    localparam logic [15:0] OUTPUT_GAIN_RST = 16'd4096;
    localparam logic [16:0] WET_MIX_RST     = 17'd32768;
    localparam logic [16:0] FEEDBACK_RST    = 17'd65536;
    localparam logic [16:0] UNITY_Q16       = 17'd65536;

    // Playback modes
    localparam logic [2:0] PM_FORWARD   = 3'd0;
    localparam logic [2:0] PM_BACKWARD  = 3'd1;
    localparam logic [2:0] PM_BOUNCE    = 3'd2;
    localparam logic [2:0] PM_ACCUM     = 3'd3;
    localparam logic [2:0] PM_ACCUM_REV = 3'd4;

    typedef enum logic [2:0] {
        M_IDLE     = 3'd0,
        M_WAITREC  = 3'd1,
        M_REC      = 3'd2,
        M_WAITSTOP = 3'd3,
        M_PLAY     = 3'd4,
        M_STOPPED  = 3'd5
    } t_looper_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PROC,
        S_RD,
        S_MIX,
        S_SW_RA,
        S_SW_RB,
        S_SW_WJ,
        S_SW_WK,
        S_SW_W1,
        S_OUT
    } t_seq_state;

    typedef enum logic [1:0] {
        WR_GAIN,
        WR_ODUB,
        WR_SCL_RD,
        WR_SCL_HOLD
    } t_wr_sel;

    // Per-cycle commands from the sequencer to both channel lanes
    typedef struct packed {
        logic    load;
        logic    rd_en;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    hold_en;
        logic    mix1;
        logic    mix2;
    } t_lane_ctl;

endpackage

/* rtl/stereo_audio_looper.sv */
`timescale 1ns / 1ps
// Each request passes S_PROC and S_OUT when dry or recording, with S_RD and S_MIX between them when playing;
// the result is registered when S_OUT sees the output free. One request at a time: input stalls until idle.
// A loop wrap (and an accumulate-reverse start) sweeps the store through the one read port and
// the one write port of each channel's loop memory.
// Reset (synchronous, active low) clears control, status and config; store contents stay.
module stereo_audio_looper import sal_pkg::*; #(
    parameter int unsigned LOOP_DEPTH  = LOOP_DEPTH_DEF,
    parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int unsigned AW = $clog2(LOOP_DEPTH),
    localparam int unsigned LW = AW + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_in_left,
    input  logic signed [SAMPLE_BITS-1:0] i_in_right,
    input  logic                          i_cmd_record,
    input  logic                          i_cmd_stop,
    input  logic                          i_cmd_clear,
    input  logic                          i_bar_boundary,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_out_left,
    output logic signed [SAMPLE_BITS-1:0] o_out_right,
    output logic [2:0]                    o_looper_mode,
    output logic [AW-1:0]                 o_play_position,
    output logic [LW-1:0]                 o_loop_size,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data
);

    logic [15:0] r_in_gain, r_out_gain;
    logic [16:0] r_wet_mix, r_feedback;
    logic [2:0]  r_pm;
    logic        r_sync;
    logic [7:0]  r_btr;

    logic [16:0]   mix_c, fb_c;
    t_lane_ctl     lane_ctl;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          load_out, use_mix, out_free;
    logic [2:0]    mode;
    logic [AW-1:0] pos;
    logic [LW-1:0] size;
    logic signed [SAMPLE_BITS-1:0] l_dry, l_mix, r_dry, r_mix;

    logic                          r_ov;
    logic signed [SAMPLE_BITS-1:0] r_out_l, r_out_r;
    logic [2:0]                    r_out_mode;
    logic [AW-1:0]                 r_out_pos;
    logic [LW-1:0]                 r_out_size;

    // Config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_gain  <= INPUT_GAIN_RST;
            r_out_gain <= OUTPUT_GAIN_RST;
            r_wet_mix  <= WET_MIX_RST;
            r_feedback <= FEEDBACK_RST;
            r_pm       <= PM_FORWARD;
            r_sync     <= 1'b0;
            r_btr      <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_INPUT_GAIN:    r_in_gain  <= i_cfg_data[15:0];
                CFG_OUTPUT_GAIN:   r_out_gain <= i_cfg_data[15:0];
                CFG_WET_MIX:       r_wet_mix  <= i_cfg_data;
                CFG_FEEDBACK:      r_feedback <= i_cfg_data;
                CFG_PLAYBACK_MODE: r_pm       <= i_cfg_data[2:0];
                CFG_SYNC_ENABLE:   r_sync     <= i_cfg_data[0];
                CFG_BARS_TO_REC:   r_btr      <= i_cfg_data[7:0];
                default:           r_sync     <= r_sync;
            endcase
        end
    end

    // Mix and feedback saturate at unity
    assign mix_c = (r_wet_mix > UNITY_Q16) ? UNITY_Q16 : r_wet_mix;
    assign fb_c  = (r_feedback > UNITY_Q16) ? UNITY_Q16 : r_feedback;

    assign out_free = !r_ov || !i_out_stall;

    sal_ctrl #(
        .LOOP_DEPTH (LOOP_DEPTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_cmd_record   (i_cmd_record),
        .i_cmd_stop     (i_cmd_stop),
        .i_cmd_clear    (i_cmd_clear),
        .i_bar_boundary (i_bar_boundary),
        .i_pm           (r_pm),
        .i_sync         (r_sync),
        .i_btr          (r_btr),
        .i_out_free     (out_free),
        .o_in_stall     (o_in_stall),
        .o_lane         (lane_ctl),
        .o_rd_addr      (rd_addr),
        .o_wr_addr      (wr_addr),
        .o_load_out     (load_out),
        .o_use_mix      (use_mix),
        .o_mode         (mode),
        .o_pos          (pos),
        .o_size         (size)
    );

    sal_lane #(
        .LOOP_DEPTH  (LOOP_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_left (
        .i_clk      (i_clk),
        .i_ctl      (lane_ctl),
        .i_rd_addr  (rd_addr),
        .i_wr_addr  (wr_addr),
        .i_x        (i_in_left),
        .i_in_gain  (r_in_gain),
        .i_out_gain (r_out_gain),
        .i_mix      (mix_c),
        .i_fb       (fb_c),
        .o_dry      (l_dry),
        .o_mix      (l_mix)
    );

    sal_lane #(
        .LOOP_DEPTH  (LOOP_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_right (
        .i_clk      (i_clk),
        .i_ctl      (lane_ctl),
        .i_rd_addr  (rd_addr),
        .i_wr_addr  (wr_addr),
        .i_x        (i_in_right),
        .i_in_gain  (r_in_gain),
        .i_out_gain (r_out_gain),
        .i_mix      (mix_c),
        .i_fb       (fb_c),
        .o_dry      (r_dry),
        .o_mix      (r_mix)
    );

    // Output register merges both lanes and status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load_out) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_l    <= use_mix ? l_mix : l_dry;
            r_out_r    <= use_mix ? r_mix : r_dry;
            r_out_mode <= mode;
            r_out_pos  <= pos;
            r_out_size <= size;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_out_left      = r_out_l;
    assign o_out_right     = r_out_r;
    assign o_looper_mode   = r_out_mode;
    assign o_play_position = r_out_pos;
    assign o_loop_size     = r_out_size;

endmodule

/* rtl/sal_lane.sv */
`timescale 1ns / 1ps
module sal_lane import sal_pkg::*; #(
    parameter int unsigned LOOP_DEPTH  = LOOP_DEPTH_DEF,
    parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int unsigned AW = $clog2(LOOP_DEPTH)
) (
    input  logic                          i_clk,
    input  t_lane_ctl                     i_ctl,
    input  logic [AW-1:0]                 i_rd_addr,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic [15:0]                   i_in_gain,
    input  logic [15:0]                   i_out_gain,
    input  logic [16:0]                   i_mix,
    input  logic [16:0]                   i_fb,
    output logic signed [SAMPLE_BITS-1:0] o_dry,
    output logic signed [SAMPLE_BITS-1:0] o_mix
);

    localparam int unsigned SW = SAMPLE_BITS;
    localparam int unsigned WW = SW + 40;
    localparam logic signed [WW-1:0] SMAX = WW'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [WW-1:0] SMIN = ~SMAX;

    // Round half up at bit s, then floor
    function automatic logic signed [WW-1:0] rnd(input logic signed [WW-1:0] v,
                                                 input int unsigned s);
        rnd = (v + (WW'(64'sd1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [SW-1:0] sat(input logic signed [WW-1:0] v);
        if (v > SMAX) begin
            sat = SMAX[SW-1:0];
        end else if (v < SMIN) begin
            sat = SMIN[SW-1:0];
        end else begin
            sat = v[SW-1:0];
        end
    endfunction

    logic signed [SW-1:0]  r_mem [LOOP_DEPTH];
    logic signed [SW-1:0]  r_x, r_g, r_o, r_rdata, r_hold;
    logic signed [SW+17:0] r_p1, r_p2;
    logic signed [SW+35:0] r_m;

    logic signed [SW+16:0] ig_pr, og_pr;
    logic signed [SW+17:0] fb_rd, fb_hold, p1, p2;
    logic signed [SW+18:0] mix_sum;
    logic signed [SW+35:0] m_pr;
    logic signed [SW:0]    od_sum;
    logic [16:0]           dry_w;
    logic signed [SW-1:0]  wdata;

    // Input gains
    assign ig_pr = i_x * $signed({1'b0, i_in_gain});
    assign og_pr = i_x * $signed({1'b0, i_out_gain});

    // Feedback scaling for the wrap sweep
    assign fb_rd   = r_rdata * $signed({1'b0, i_fb});
    assign fb_hold = r_hold * $signed({1'b0, i_fb});

    // Wet/dry mix products
    assign dry_w   = 17'(18'd65536 - {1'b0, i_mix});
    assign p1      = r_x * $signed({1'b0, dry_w});
    assign p2      = r_rdata * $signed({1'b0, i_mix});
    assign mix_sum = r_p1 + r_p2;
    assign m_pr    = mix_sum * $signed({1'b0, i_out_gain});

    assign od_sum = r_rdata + r_g;

    // Store write data
    always_comb begin
        unique case (i_ctl.wr_sel)
            WR_GAIN:     wdata = r_g;
            WR_ODUB:     wdata = sat(WW'(od_sum));
            WR_SCL_RD:   wdata = sat(rnd(WW'(fb_rd), 16));
            WR_SCL_HOLD: wdata = sat(rnd(WW'(fb_hold), 16));
            default:     wdata = r_g;
        endcase
    end

    // Loop store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    // Sample datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x <= i_x;
            r_g <= sat(rnd(WW'(ig_pr), 12));
            r_o <= sat(rnd(WW'(og_pr), 12));
        end
        if (i_ctl.hold_en) begin
            r_hold <= r_rdata;
        end
        if (i_ctl.mix1) begin
            r_p1 <= p1;
            r_p2 <= p2;
        end
        if (i_ctl.mix2) begin
            r_m <= m_pr;
        end
    end

    assign o_dry = r_o;
    assign o_mix = sat(rnd(WW'(r_m), 28));

endmodule

/* rtl/sal_ctrl.sv */
`timescale 1ns / 1ps
module sal_ctrl import sal_pkg::*; #(
    parameter int unsigned LOOP_DEPTH = LOOP_DEPTH_DEF,
    localparam int unsigned AW = $clog2(LOOP_DEPTH),
    localparam int unsigned LW = AW + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_cmd_record,
    input  logic          i_cmd_stop,
    input  logic          i_cmd_clear,
    input  logic          i_bar_boundary,
    input  logic [2:0]    i_pm,
    input  logic          i_sync,
    input  logic [7:0]    i_btr,
    input  logic          i_out_free,
    output logic          o_in_stall,
    output t_lane_ctl     o_lane,
    output logic [AW-1:0] o_rd_addr,
    output logic [AW-1:0] o_wr_addr,
    output logic          o_load_out,
    output logic          o_use_mix,
    output logic [2:0]    o_mode,
    output logic [AW-1:0] o_pos,
    output logic [LW-1:0] o_size
);

`include "stereo_audio_looper_macros.svh"

    localparam logic [LW-1:0] DEPTH_L = LW'(LOOP_DEPTH);

    t_seq_state   r_state, n_state;
    t_looper_mode r_mode, n_mode;
    logic [LW-1:0] r_rp, n_rp, r_ll, n_ll, r_rem, n_rem;
    logic [AW-1:0] r_ph, n_ph, r_j, n_j, r_k, n_k, r_addr, n_addr;
    logic [7:0]    r_bars, n_bars;
    logic r_bounce, n_bounce, r_flip, n_flip, r_ret_proc, n_ret_proc;
    logic r_sw_pend, n_sw_pend, r_overdub, n_overdub, r_use_mix, n_use_mix;

    logic          accept, rec_path, rp_ok, play_path;
    logic [AW-1:0] phe;
    logic [LW-1:0] rp1;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign rec_path  = (r_mode == M_REC) || (r_mode == M_WAITSTOP);
    assign rp_ok     = r_rp < DEPTH_L;
    assign play_path = (r_mode == M_PLAY) && (r_ll != '0);
    assign phe       = ({1'b0, r_ph} >= r_ll) ? '0 : r_ph;
    assign rp1       = r_rp + LW'(1);

    // Next state and sequencer registers
    always_comb begin
        t_looper_mode  m;
        logic [LW-1:0] rp, ll;
        logic [AW-1:0] ph, p;
        logic [7:0]    bars;
        logic          bounce, start, wrap;

        n_state    = r_state;
        n_mode     = r_mode;
        n_rp       = r_rp;
        n_ph       = r_ph;
        n_ll       = r_ll;
        n_bounce   = r_bounce;
        n_bars     = r_bars;
        n_j        = r_j;
        n_k        = r_k;
        n_rem      = r_rem;
        n_flip     = r_flip;
        n_ret_proc = r_ret_proc;
        n_sw_pend  = r_sw_pend;
        n_addr     = r_addr;
        n_overdub  = r_overdub;
        n_use_mix  = r_use_mix;
        m      = r_mode;
        rp     = r_rp;
        ll     = r_ll;
        ph     = r_ph;
        bars   = r_bars;
        bounce = r_bounce;
        start  = 1'b0;
        wrap   = 1'b0;
        p      = r_ph;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    // Commands: clear, record, stop, bar, in that order
                    if (i_cmd_clear) begin
                        rp = '0; bars = '0; ll = '0; ph = '0; m = M_IDLE;
                    end
                    if (i_cmd_record && !i_cmd_clear &&
                        (m == M_IDLE || m == M_STOPPED)) begin
                        rp = '0; bars = '0; ll = '0;
                        m = i_sync ? M_WAITREC : M_REC;
                    end
                    if (i_cmd_stop && !i_cmd_clear) begin
                        unique case (m)
                            M_REC: begin
                                if (i_sync) begin
                                    m = M_WAITSTOP;
                                end else begin
                                    start = 1'b1;
                                end
                            end
                            M_WAITREC: m = M_IDLE;
                            M_PLAY:    m = M_STOPPED;
                            default: ;
                        endcase
                    end
                    if (start) begin
                        m = M_PLAY; ll = rp; ph = '0; bounce = 1'b0;
                    end
                    if (i_bar_boundary) begin
                        unique case (m)
                            M_WAITREC: begin
                                rp = '0; bars = '0; m = M_REC;
                            end
                            M_REC: begin
                                if (bars != 8'hFF) begin
                                    bars = bars + 8'd1;
                                end
                                if (i_btr != '0 && bars >= i_btr) begin
                                    start = 1'b1;
                                    m = M_PLAY; ll = rp; ph = '0; bounce = 1'b0;
                                end
                            end
                            M_WAITSTOP: begin
                                start = 1'b1;
                                m = M_PLAY; ll = rp; ph = '0; bounce = 1'b0;
                            end
                            default: ;
                        endcase
                    end
                    n_mode    = m;
                    n_rp      = rp;
                    n_ll      = ll;
                    n_ph      = ph;
                    n_bars    = bars;
                    n_bounce  = bounce;
                    n_use_mix = 1'b0;
                    // Accumulate-reverse sweeps the fresh loop before playing it
                    if (start && i_pm == PM_ACCUM_REV) begin
                        n_j        = '0;
                        n_k        = AW'(rp - LW'(1));
                        n_rem      = rp;
                        n_flip     = 1'b1;
                        n_ret_proc = 1'b1;
                        n_state    = S_SW_RA;
                    end else begin
                        n_state = S_PROC;
                    end
                end
            end

            S_PROC: begin
                n_ret_proc = 1'b0;
                n_sw_pend  = 1'b0;
                n_overdub  = 1'b0;
                n_use_mix  = 1'b0;
                n_state    = S_OUT;
                if (rec_path) begin
                    if (rp_ok) begin
                        n_rp = rp1;
                        // Store full: playback starts
                        if (rp1 >= DEPTH_L) begin
                            n_ll     = rp1;
                            n_ph     = '0;
                            n_bounce = 1'b0;
                            n_mode   = M_PLAY;
                            if (i_pm == PM_ACCUM_REV) begin
                                n_j     = '0;
                                n_k     = AW'(rp1 - LW'(1));
                                n_rem   = rp1;
                                n_flip  = 1'b1;
                                n_state = S_SW_RA;
                            end
                        end
                    end
                end else if (play_path) begin
                    // Playhead step
                    priority if (i_pm == PM_BACKWARD) begin
                        if (phe == '0) begin
                            wrap = 1'b1;
                            p = AW'(r_ll - LW'(1));
                        end else begin
                            p = phe - AW'(1);
                        end
                    end else if (i_pm == PM_BOUNCE) begin
                        if (!r_bounce) begin
                            if ((LW'(phe) + LW'(1)) >= r_ll) begin
                                p = (r_ll >= LW'(2)) ? AW'(r_ll - LW'(2)) : '0;
                                bounce = 1'b1;
                            end else begin
                                p = phe + AW'(1);
                            end
                        end else begin
                            if (phe == '0) begin
                                wrap = 1'b1;
                                p = (r_ll >= LW'(2)) ? AW'(1) : '0;
                                bounce = 1'b0;
                            end else begin
                                p = phe - AW'(1);
                            end
                        end
                    end else begin
                        if ((LW'(phe) + LW'(1)) >= r_ll) begin
                            wrap = 1'b1;
                            p = '0;
                        end else begin
                            p = phe + AW'(1);
                        end
                    end
                    n_ph      = p;
                    n_bounce  = bounce;
                    n_addr    = phe;
                    n_overdub = (i_pm == PM_ACCUM) || (i_pm == PM_ACCUM_REV);
                    n_use_mix = 1'b1;
                    if (wrap) begin
                        n_j       = '0;
                        n_k       = AW'(r_ll - LW'(1));
                        n_rem     = r_ll;
                        n_flip    = (i_pm == PM_ACCUM_REV);
                        n_sw_pend = 1'b1;
                    end
                    n_state = S_RD;
                end
            end

            S_RD: n_state = S_MIX;

            S_MIX: begin
                n_sw_pend = 1'b0;
                n_state   = r_sw_pend ? S_SW_RA : S_OUT;
            end

            // Wrap sweep: scale, and swap ends when flipping
            S_SW_RA: begin
                if (r_rem == '0) begin
                    n_state = r_ret_proc ? S_PROC : S_OUT;
                end else if (r_flip && r_rem >= LW'(2)) begin
                    n_state = S_SW_RB;
                end else begin
                    n_state = S_SW_W1;
                end
            end

            S_SW_RB: n_state = S_SW_WJ;

            S_SW_WJ: n_state = S_SW_WK;

            S_SW_WK: begin
                n_j     = r_j + AW'(1);
                n_k     = r_k - AW'(1);
                n_rem   = r_rem - LW'(2);
                n_state = S_SW_RA;
            end

            S_SW_W1: begin
                n_j     = r_j + AW'(1);
                n_rem   = r_rem - LW'(1);
                n_state = S_SW_RA;
            end

            S_OUT: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Lane commands and store addresses
    always_comb begin
        o_lane     = '0;
        o_rd_addr  = '0;
        o_wr_addr  = '0;
        o_load_out = 1'b0;
        unique case (r_state)
            S_IDLE: o_lane.load = accept;
            S_PROC: begin
                if (rec_path && rp_ok) begin
                    o_lane.wr_en  = 1'b1;
                    o_lane.wr_sel = WR_GAIN;
                    o_wr_addr     = r_rp[AW-1:0];
                end else if (!rec_path && play_path) begin
                    o_lane.rd_en = 1'b1;
                    o_rd_addr    = phe;
                end
            end
            S_RD: begin
                o_lane.mix1   = 1'b1;
                o_lane.wr_en  = r_overdub;
                o_lane.wr_sel = WR_ODUB;
                o_wr_addr     = r_addr;
            end
            S_MIX: o_lane.mix2 = 1'b1;
            S_SW_RA: begin
                o_lane.rd_en = (r_rem != '0);
                o_rd_addr    = r_j;
            end
            S_SW_RB: begin
                o_lane.rd_en   = 1'b1;
                o_lane.hold_en = 1'b1;
                o_rd_addr      = r_k;
            end
            S_SW_WJ, S_SW_W1: begin
                o_lane.wr_en  = 1'b1;
                o_lane.wr_sel = WR_SCL_RD;
                o_wr_addr     = r_j;
            end
            S_SW_WK: begin
                o_lane.wr_en  = 1'b1;
                o_lane.wr_sel = WR_SCL_HOLD;
                o_wr_addr     = r_k;
            end
            S_OUT: o_load_out = i_out_free;
            default: o_load_out = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mode     <= M_IDLE;
            r_rp       <= '0;
            r_ph       <= '0;
            r_ll       <= '0;
            r_bounce   <= 1'b0;
            r_bars     <= '0;
            r_rem      <= '0;
            r_flip     <= 1'b0;
            r_ret_proc <= 1'b0;
            r_sw_pend  <= 1'b0;
            r_overdub  <= 1'b0;
            r_use_mix  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_mode     <= n_mode;
            r_rp       <= n_rp;
            r_ph       <= n_ph;
            r_ll       <= n_ll;
            r_bounce   <= n_bounce;
            r_bars     <= n_bars;
            r_rem      <= n_rem;
            r_flip     <= n_flip;
            r_ret_proc <= n_ret_proc;
            r_sw_pend  <= n_sw_pend;
            r_overdub  <= n_overdub;
            r_use_mix  <= n_use_mix;
        end
    end

    // Sweep indexes and playback address
    always_ff @(posedge i_clk) begin
        r_j    <= n_j;
        r_k    <= n_k;
        r_addr <= n_addr;
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_use_mix  = r_use_mix;
    assign o_mode     = r_mode;
    assign o_pos      = r_ph;
    assign o_size     = r_ll;

    `SAL_ASSERT(a_rp_range, i_clk, i_rst_n, r_rp <= DEPTH_L)
    `SAL_ASSERT(a_ll_range, i_clk, i_rst_n, r_ll <= DEPTH_L)
    `SAL_ASSERT(a_ph_in_loop, i_clk, i_rst_n, (r_state == S_IDLE && r_mode == M_PLAY && r_ll != '0) |-> ({1'b0, r_ph} < r_ll))
    `SAL_ASSERT(a_sweep_nonempty, i_clk, i_rst_n, (r_state == S_SW_W1 || r_state == S_SW_WK) |-> (r_rem != '0))
    `SAL_ASSERT_NEXT(a_pair_done, i_clk, i_rst_n, r_state == S_SW_WK, r_state == S_SW_RA)

endmodule
